>>> rtl/core/ffcha_pkg.sv
// Package for the first-fit chunk heap allocator: sizes, codes, the work item
// that passes from the front end to the back end, and the heap size clamp.
// Depends on nothing; every other file of the block but ffcha_ram uses it.
package ffcha_pkg;

   localparam int MAX_CHUNKS  = 64;
   localparam int IDX_W       = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int CNT_W       = $clog2(MAX_CHUNKS + 1);
   localparam int SIZE_W      = 25;
   localparam int ADDR_W      = 32;
   localparam int START_W     = 24;
   localparam int STATUS_W    = 3;
   localparam int CMD_W       = 2;
   localparam int CSR_W       = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CHUNK_W     = START_W + SIZE_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SIZE_W-1:0] HEAP_LIMIT = SIZE_W'(1 << START_W);
   localparam logic [SIZE_W-1:0] BYTES_MAX  = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_SIZE    = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK         = 3'd0,
      STS_BAD_SIZE   = 3'd1,
      STS_NO_MEMORY  = 3'd2,
      STS_TABLE_FULL = 3'd3,
      STS_UNTRACKED  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_ALLOC    = 3'd0,
      OP_FREE     = 3'd1,
      OP_QUERY    = 3'd2,
      OP_CLEAR    = 3'd3,
      OP_BAD_SIZE = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE   = 3'b001,
      BK_SCAN   = 3'b010,
      BK_FINISH = 3'b100
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [SIZE_W-1:0]   request_bytes;
      logic [ADDR_W-1:0]   offset;
      logic                inside_heap;
   } work_type;

   function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] heap_size);
      effective_size = (heap_size > HEAP_LIMIT) ? HEAP_LIMIT : heap_size;
   endfunction

endpackage

>>> rtl/core/ffcha_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ffcha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ffcha_front.sv
// Front end: takes request items, checks the allocation size, works out the
// heap offset and the membership test, and hands a work item to the queue.
// Depends on ffcha_pkg.
module ffcha_front (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ffcha_pkg::CMD_W-1:0]   req_command,
   input  logic [ffcha_pkg::SIZE_W-1:0]  req_request_bytes,
   input  logic [ffcha_pkg::ADDR_W-1:0]  req_target_address,
   input  logic [ffcha_pkg::ADDR_W-1:0]  base_address,
   input  logic [ffcha_pkg::SIZE_W-1:0]  heap_size,
   input  logic                          queue_full,
   output logic                          push,
   output ffcha_pkg::work_type           push_data
);

   logic [ffcha_pkg::SIZE_W-1:0] eff_size;
   logic                         bad_size;
   logic [ffcha_pkg::ADDR_W:0]   heap_end;
   logic                         in_range;

   always_comb begin
      eff_size = ffcha_pkg::effective_size(heap_size);
      bad_size = (req_request_bytes == '0) || (req_request_bytes > eff_size);
      heap_end = {1'b0, base_address}
               + {{(ffcha_pkg::ADDR_W + 1 - ffcha_pkg::SIZE_W){1'b0}}, eff_size};
      in_range = (req_target_address >= base_address)
              && ({1'b0, req_target_address} < heap_end);

      push_data.request_bytes = req_request_bytes;
      push_data.offset        = req_target_address - base_address;
      push_data.inside_heap   = 1'b0;
      case (ffcha_pkg::cmd_type'(req_command))
         ffcha_pkg::CMD_ALLOC: begin
            push_data.op = bad_size ? ffcha_pkg::OP_BAD_SIZE : ffcha_pkg::OP_ALLOC;
         end
         ffcha_pkg::CMD_FREE: begin
            push_data.op = ffcha_pkg::OP_FREE;
         end
         ffcha_pkg::CMD_QUERY: begin
            push_data.op          = ffcha_pkg::OP_QUERY;
            push_data.inside_heap = in_range;
         end
         default: begin
            push_data.op = ffcha_pkg::OP_CLEAR;
         end
      endcase
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

endmodule

>>> rtl/core/ffcha_queue.sv
// Short work queue between the front end and the back end.
// Depends on ffcha_pkg.
module ffcha_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ffcha_pkg::work_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output ffcha_pkg::work_type head_data
);

   ffcha_pkg::work_type                entries_ff [ffcha_pkg::QUEUE_DEPTH];
   logic [ffcha_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ffcha_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ffcha_pkg::QCNT_W-1:0]       count_ff, count_in;

   function automatic logic [ffcha_pkg::QPTR_W-1:0] next_ptr(
      input logic [ffcha_pkg::QPTR_W-1:0] ptr);
      if (ptr == ffcha_pkg::QPTR_W'(ffcha_pkg::QUEUE_DEPTH - 1)) begin
         next_ptr = '0;
      end else begin
         next_ptr = ptr + 1'b1;
      end
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = (count_ff == ffcha_pkg::QCNT_W'(ffcha_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entries_ff[rd_ptr_ff];

endmodule

>>> rtl/core/ffcha_back.sv
// Back end: scans the chunk table one entry a cycle, reuses, appends, releases or
// clears chunks, keeps the used-byte count and holds the response register.
// Depends on ffcha_pkg and ffcha_ram.
module ffcha_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  ffcha_pkg::work_type             head_data,
   output logic                            pop,
   input  logic [ffcha_pkg::ADDR_W-1:0]    base_address,
   input  logic [ffcha_pkg::SIZE_W-1:0]    heap_size,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ffcha_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ffcha_pkg::ADDR_W-1:0]    rsp_granted_address,
   output logic                            rsp_inside_heap,
   output logic [ffcha_pkg::SIZE_W-1:0]    rsp_bytes_in_use
);

   localparam int PAD_START = ffcha_pkg::ADDR_W - ffcha_pkg::START_W;
   localparam int PAD_SIZE  = ffcha_pkg::ADDR_W - ffcha_pkg::SIZE_W;

   ffcha_pkg::back_state_type              state_ff, state_in;
   ffcha_pkg::work_type                    work_ff, work_in;
   logic [ffcha_pkg::CNT_W-1:0]            rd_idx_ff, rd_idx_in;
   logic                                   chk_valid_ff, chk_valid_in;
   logic [ffcha_pkg::IDX_W-1:0]            chk_idx_ff, chk_idx_in;
   logic                                   found_ff, found_in;
   logic [ffcha_pkg::IDX_W-1:0]            hit_idx_ff, hit_idx_in;
   logic [ffcha_pkg::START_W-1:0]          hit_start_ff, hit_start_in;
   logic [ffcha_pkg::SIZE_W-1:0]           hit_len_ff, hit_len_in;
   logic [ffcha_pkg::MAX_CHUNKS-1:0]       in_use_ff, in_use_in;
   logic [ffcha_pkg::CNT_W-1:0]            chunk_count_ff, chunk_count_in;
   logic [ffcha_pkg::SIZE_W-1:0]           end_ff, end_in;
   logic [ffcha_pkg::SIZE_W-1:0]           used_ff, used_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [ffcha_pkg::STATUS_W-1:0]         rsp_status_ff, rsp_status_in;
   logic [ffcha_pkg::ADDR_W-1:0]           rsp_granted_ff, rsp_granted_in;
   logic                                   rsp_inside_ff, rsp_inside_in;
   logic [ffcha_pkg::SIZE_W-1:0]           rsp_bytes_ff, rsp_bytes_in;

   logic                                   wr_en;
   logic [ffcha_pkg::CHUNK_W-1:0]          wr_data;
   logic [ffcha_pkg::CHUNK_W-1:0]          rd_data;
   logic [ffcha_pkg::START_W-1:0]          ram_start;
   logic [ffcha_pkg::SIZE_W-1:0]           ram_len;
   logic                                   hit;
   logic                                   out_free;
   logic [ffcha_pkg::SIZE_W-1:0]           eff_size;
   logic [ffcha_pkg::SIZE_W:0]             reuse_sum;
   logic [ffcha_pkg::SIZE_W:0]             append_used;
   logic [ffcha_pkg::SIZE_W:0]             append_end;

   ffcha_ram #(
      .WIDTH (ffcha_pkg::CHUNK_W),
      .DEPTH (ffcha_pkg::MAX_CHUNKS)
   ) u_chunk_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (chunk_count_ff[ffcha_pkg::IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_idx_ff[ffcha_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      ram_start   = rd_data[ffcha_pkg::CHUNK_W-1:ffcha_pkg::SIZE_W];
      ram_len     = rd_data[ffcha_pkg::SIZE_W-1:0];
      wr_data     = {end_ff[ffcha_pkg::START_W-1:0], work_ff.request_bytes};
      out_free    = !rsp_valid_ff || rsp_ready;
      eff_size    = ffcha_pkg::effective_size(heap_size);
      reuse_sum   = {1'b0, used_ff} + {1'b0, hit_len_ff};
      append_used = {1'b0, used_ff} + {1'b0, work_ff.request_bytes};
      append_end  = {1'b0, end_ff} + {1'b0, work_ff.request_bytes};

      if (work_ff.op == ffcha_pkg::OP_FREE) begin
         hit = in_use_ff[chk_idx_ff]
            && ({{PAD_START{1'b0}}, ram_start} == work_ff.offset);
      end else begin
         hit = !in_use_ff[chk_idx_ff] && (ram_len >= work_ff.request_bytes);
      end

      state_in       = state_ff;
      work_in        = work_ff;
      rd_idx_in      = rd_idx_ff;
      chk_valid_in   = 1'b0;
      chk_idx_in     = chk_idx_ff;
      found_in       = found_ff;
      hit_idx_in     = hit_idx_ff;
      hit_start_in   = hit_start_ff;
      hit_len_in     = hit_len_ff;
      in_use_in      = in_use_ff;
      chunk_count_in = chunk_count_ff;
      end_in         = end_ff;
      used_in        = used_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_inside_in  = rsp_inside_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      pop            = 1'b0;
      wr_en          = 1'b0;

      case (state_ff)
         ffcha_pkg::BK_IDLE: begin
            if (head_valid) begin
               pop       = 1'b1;
               work_in   = head_data;
               rd_idx_in = '0;
               found_in  = 1'b0;
               if ((head_data.op == ffcha_pkg::OP_ALLOC)
                   || (head_data.op == ffcha_pkg::OP_FREE)) begin
                  state_in = ffcha_pkg::BK_SCAN;
               end else begin
                  state_in = ffcha_pkg::BK_FINISH;
               end
            end
         end
         ffcha_pkg::BK_SCAN: begin
            if (chk_valid_ff && hit) begin
               found_in     = 1'b1;
               hit_idx_in   = chk_idx_ff;
               hit_start_in = ram_start;
               hit_len_in   = ram_len;
               state_in     = ffcha_pkg::BK_FINISH;
            end else if (rd_idx_ff < chunk_count_ff) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_idx_ff[ffcha_pkg::IDX_W-1:0];
               rd_idx_in    = rd_idx_ff + 1'b1;
            end else if (!chk_valid_ff) begin
               state_in = ffcha_pkg::BK_FINISH;
            end
         end
         ffcha_pkg::BK_FINISH: begin
            if (out_free) begin
               state_in       = ffcha_pkg::BK_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ffcha_pkg::STS_OK;
               rsp_granted_in = '0;
               rsp_inside_in  = 1'b0;
               case (work_ff.op)
                  ffcha_pkg::OP_ALLOC: begin
                     if (found_ff) begin
                        in_use_in[hit_idx_ff] = 1'b1;
                        used_in        = reuse_sum[ffcha_pkg::SIZE_W]
                                       ? ffcha_pkg::BYTES_MAX
                                       : reuse_sum[ffcha_pkg::SIZE_W-1:0];
                        rsp_granted_in = base_address + {{PAD_START{1'b0}}, hit_start_ff};
                     end else if (append_end > {1'b0, eff_size}) begin
                        rsp_status_in = ffcha_pkg::STS_NO_MEMORY;
                     end else if (chunk_count_ff >=
                                  ffcha_pkg::CNT_W'(ffcha_pkg::MAX_CHUNKS)) begin
                        rsp_status_in = ffcha_pkg::STS_TABLE_FULL;
                     end else begin
                        wr_en = 1'b1;
                        in_use_in[chunk_count_ff[ffcha_pkg::IDX_W-1:0]] = 1'b1;
                        chunk_count_in = chunk_count_ff + 1'b1;
                        end_in         = append_end[ffcha_pkg::SIZE_W-1:0];
                        used_in        = append_used[ffcha_pkg::SIZE_W]
                                       ? ffcha_pkg::BYTES_MAX
                                       : append_used[ffcha_pkg::SIZE_W-1:0];
                        rsp_granted_in = base_address + {{PAD_SIZE{1'b0}}, end_ff};
                     end
                  end
                  ffcha_pkg::OP_FREE: begin
                     if (found_ff) begin
                        in_use_in[hit_idx_ff] = 1'b0;
                        used_in = (used_ff >= hit_len_ff) ? (used_ff - hit_len_ff) : '0;
                     end else begin
                        rsp_status_in = ffcha_pkg::STS_UNTRACKED;
                     end
                  end
                  ffcha_pkg::OP_QUERY: begin
                     rsp_inside_in = work_ff.inside_heap;
                  end
                  ffcha_pkg::OP_BAD_SIZE: begin
                     rsp_status_in = ffcha_pkg::STS_BAD_SIZE;
                  end
                  default: begin
                     in_use_in      = '0;
                     chunk_count_in = '0;
                     end_in         = '0;
                     used_in        = '0;
                  end
               endcase
               rsp_bytes_in = used_in;
            end
         end
         default: begin
            state_in = ffcha_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ffcha_pkg::BK_IDLE;
         chk_valid_ff   <= 1'b0;
         in_use_ff      <= '0;
         chunk_count_ff <= '0;
         end_ff         <= '0;
         used_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         chk_valid_ff   <= chk_valid_in;
         in_use_ff      <= in_use_in;
         chunk_count_ff <= chunk_count_in;
         end_ff         <= end_in;
         used_ff        <= used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff        <= work_in;
      rd_idx_ff      <= rd_idx_in;
      chk_idx_ff     <= chk_idx_in;
      found_ff       <= found_in;
      hit_idx_ff     <= hit_idx_in;
      hit_start_ff   <= hit_start_in;
      hit_len_ff     <= hit_len_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_inside_ff  <= rsp_inside_in;
      rsp_bytes_ff   <= rsp_bytes_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign rsp_inside_heap     = rsp_inside_ff;
   assign rsp_bytes_in_use    = rsp_bytes_ff;

endmodule

>>> rtl/core/first_fit_chunk_heap_allocator.sv
// Top level of the first-fit chunk heap allocator: configuration registers,
// front end, work queue and back end.
// Depends on ffcha_pkg, ffcha_front, ffcha_queue and ffcha_back.
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_ready  command, request_bytes, target_address
//   rsp_     out        rsp_valid/rsp_ready  status, granted_address, inside_heap,
//                                            bytes_in_use
//   csr_     in         csr_write_enable     csr_index, csr_write_data
//
// With the back end idle, an allocate or free item passes from acceptance through the queue
// to a scan of the chunk table, which stops at the first matching entry or after the last
// one, and then to the output register; query, clear and bad-size items skip the scan. The
// back end reads one chunk RAM entry a cycle while it scans.
// Reset empties the table at once through the in-use flags and the chunk count.
// The front end keeps taking items while the two-entry queue has room, and the back
// end holds a finished result in its output register while the response is stalled.
module first_fit_chunk_heap_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ffcha_pkg::CMD_W-1:0]       req_command,
   input  logic [ffcha_pkg::SIZE_W-1:0]      req_request_bytes,
   input  logic [ffcha_pkg::ADDR_W-1:0]      req_target_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ffcha_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ffcha_pkg::ADDR_W-1:0]      rsp_granted_address,
   output logic                              rsp_inside_heap,
   output logic [ffcha_pkg::SIZE_W-1:0]      rsp_bytes_in_use,
   input  logic                              csr_write_enable,
   input  logic [ffcha_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ffcha_pkg::CSR_W-1:0]       csr_write_data
);

   logic [ffcha_pkg::ADDR_W-1:0] base_address_ff, base_address_in;
   logic [ffcha_pkg::SIZE_W-1:0] heap_size_ff, heap_size_in;

   logic                         queue_full;
   logic                         push;
   ffcha_pkg::work_type          push_data;
   logic                         pop;
   logic                         head_valid;
   ffcha_pkg::work_type          head_data;

   always_comb begin
      base_address_in = base_address_ff;
      heap_size_in    = heap_size_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ffcha_pkg::CSR_BASE_ADDRESS: begin
               base_address_in = csr_write_data[ffcha_pkg::ADDR_W-1:0];
            end
            ffcha_pkg::CSR_HEAP_SIZE: begin
               heap_size_in = csr_write_data[ffcha_pkg::SIZE_W-1:0];
            end
            default: begin
               base_address_in = base_address_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= '0;
         heap_size_ff    <= ffcha_pkg::HEAP_LIMIT;
      end else begin
         base_address_ff <= base_address_in;
         heap_size_ff    <= heap_size_in;
      end
   end

   ffcha_front u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_request_bytes  (req_request_bytes),
      .req_target_address (req_target_address),
      .base_address       (base_address_ff),
      .heap_size          (heap_size_ff),
      .queue_full         (queue_full),
      .push               (push),
      .push_data          (push_data)
   );

   ffcha_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   ffcha_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_data           (head_data),
      .pop                 (pop),
      .base_address        (base_address_ff),
      .heap_size           (heap_size_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_inside_heap     (rsp_inside_heap),
      .rsp_bytes_in_use    (rsp_bytes_in_use)
   );

endmodule
